// ===== sv/sgnd_pkg.sv =====
`timescale 1ns / 1ps
package sgnd_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DefMaxChunks = 1024;
  localparam int unsigned DefCoordBits = 16;

  // Input field widths
  localparam int unsigned InCoordW = 16;
  localparam int unsigned IdxW     = 10;

  // Item kinds
  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_MARK  = 2'd1,
    K_READ  = 2'd2,
    K_CLEAR = 2'd3
  } kind_t;

  // Compare flags between a stored coordinate and the reference one
  typedef struct packed {
    logic eq;
    logic nbr;
  } cmp_t;

endpackage

// ===== sv/sgnd_ram.sv =====
`timescale 1ns / 1ps
module sgnd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sgnd_cmp.sv =====
`timescale 1ns / 1ps
module sgnd_cmp #(
  parameter int unsigned CB = 16
) (
  input  logic signed [CB-1:0] ax,
  input  logic signed [CB-1:0] ay,
  input  logic signed [CB-1:0] az,
  input  logic signed [CB-1:0] bx,
  input  logic signed [CB-1:0] by,
  input  logic signed [CB-1:0] bz,
  output sgnd_pkg::cmp_t       res
);
  import sgnd_pkg::*;

  logic signed [CB:0] dx, dy, dz;
  logic nx, ny, nz, ex, ey, ez;

  // differences one bit wider so they never wrap
  always_comb begin
    dx = {ax[CB-1], ax} - {bx[CB-1], bx};
    dy = {ay[CB-1], ay} - {by[CB-1], by};
    dz = {az[CB-1], az} - {bz[CB-1], bz};
    nx = (dx >= -2'sd1) && (dx <= 2'sd1);
    ny = (dy >= -2'sd1) && (dy <= 2'sd1);
    nz = (dz >= -2'sd1) && (dz <= 2'sd1);
    ex = (ax == bx);
    ey = (ay == by);
    ez = (az == bz);
    res.eq  = ex && ey && ez;
    res.nbr = nx && ny && nz && !(ex && ey && ez);
  end

endmodule

// ===== sv/sparse_grid_neighbor_dilation_core.sv =====
`timescale 1ns / 1ps
// Sparse chunk grid, 26-neighbor dilation of a shadow candidate mask.
// Input channel (in_valid/in_ready) takes one word per item: kind, coord_x/y/z,
// chunk_index. Output channel (out_valid/out_ready) gives one word per read
// item: candidate, mask_present, index_in_range, table_overflow.
// cfg_we/cfg_data write culling_on; write it only while the block is idle.
// Load, mark and read items walk a single chunk memory (coordinate, duplicate
// and mask bit per entry, one write port and one registered read port):
//   load : duplicate search over the store, then the new entry is written
//   mark : in range, the named entry is read, then the store scanned; else none
//   read : entry to the output register, clear : no memory access
// A load also zeroes the mask bit of its entry, so no clearing pass exists.
// in_ready is high only while the sequencer is idle. A finished read result
// sits in the output register; a stalled receiver holds the block only when
// the next read result is ready, other items keep going.
// Synchronous reset empties the store, clears flags and culling_on.
module sparse_grid_neighbor_dilation_core #(
  parameter int unsigned MAX_CHUNKS = sgnd_pkg::DefMaxChunks,
  parameter int unsigned COORD_BITS = sgnd_pkg::DefCoordBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           kind,
  input  logic signed [sgnd_pkg::InCoordW-1:0] coord_x,
  input  logic signed [sgnd_pkg::InCoordW-1:0] coord_y,
  input  logic signed [sgnd_pkg::InCoordW-1:0] coord_z,
  input  logic [sgnd_pkg::IdxW-1:0]            chunk_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 candidate,
  output logic                                 mask_present,
  output logic                                 index_in_range,
  output logic                                 table_overflow,
  input  logic                                 cfg_we,
  input  logic                                 cfg_data
);
  import sgnd_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned AW   = $clog2(MAX_CHUNKS);
  localparam int unsigned CW   = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned CMPW = (CW > IdxW) ? CW : IdxW;
  localparam int unsigned W    = 3 * CB + 2;
  localparam int unsigned CAND = W - 1;
  localparam int unsigned DUP  = W - 2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LSCAN = 7'b0000010,
    S_MREQ  = 7'b0000100,
    S_MBASE = 7'b0001000,
    S_MSCAN = 7'b0010000,
    S_RREQ  = 7'b0100000,
    S_RDONE = 7'b1000000
  } state_t;

  state_t           state;
  logic [CW-1:0]    count;
  logic             mark_seen, ovf, culling_on;
  logic [CW-1:0]    scan_j;
  logic             pv, dup_found;
  logic [AW-1:0]    pj, h_idx;
  logic signed [CB-1:0] h_x, h_y, h_z, in_x, in_y, in_z;
  logic             r_present, r_inrange;
  logic [CMPW-1:0]  idx_cmp, cnt_cmp;
  logic             issue, in_acc, scan_done, set_bit;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [W-1:0]     wdata, rdata;
  cmp_t             cmp;

  // coordinate at COORD_BITS: wrap below 16 bits, sign-extend above
  function automatic logic [CB-1:0] conv(input logic [InCoordW-1:0] c);
    return CB'($signed(c));
  endfunction

  assign in_x    = conv(coord_x);
  assign in_y    = conv(coord_y);
  assign in_z    = conv(coord_z);
  assign idx_cmp = CMPW'(chunk_index);
  assign cnt_cmp = CMPW'(count);

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign issue     = ((state == S_LSCAN) || (state == S_MSCAN)) && (scan_j < count);
  assign scan_done = !issue && !pv;

  // chunk memory
  sgnd_ram #(.WIDTH(W), .DEPTH(MAX_CHUNKS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sgnd_cmp #(.CB(CB)) u_cmp (
    .ax  (rdata[3*CB-1:2*CB]),
    .ay  (rdata[2*CB-1:CB]),
    .az  (rdata[CB-1:0]),
    .bx  (h_x),
    .by  (h_y),
    .bz  (h_z),
    .res (cmp)
  );

  // mark: the named entry itself, or a non-duplicate neighbor
  assign set_bit = pv && ((pj == h_idx) || (!rdata[DUP] && cmp.nbr));

  // memory port control
  always_comb begin
    raddr = h_idx;
    if (state == S_LSCAN || state == S_MSCAN) begin
      raddr = scan_j[AW-1:0];
    end
    we    = 1'b0;
    waddr = pj;
    wdata = rdata;
    wdata[CAND] = 1'b1;
    if (state == S_LSCAN && scan_done) begin
      we    = 1'b1;
      waddr = count[AW-1:0];
      wdata = {1'b0, dup_found, h_x, h_y, h_z};
    end else if (state == S_MSCAN) begin
      we = set_bit;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      mark_seen  <= 1'b0;
      ovf        <= 1'b0;
      culling_on <= 1'b0;
      pv         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        culling_on <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      pv <= issue;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (kind_t'(kind))
              K_LOAD: begin
                if (count >= CW'(MAX_CHUNKS)) begin
                  ovf <= 1'b1;
                end else begin
                  state <= S_LSCAN;
                end
              end
              K_MARK: begin
                mark_seen <= 1'b1;
                if (idx_cmp < cnt_cmp) begin
                  state <= S_MREQ;
                end
              end
              K_READ: begin
                state <= S_RREQ;
              end
              K_CLEAR: begin
                count     <= '0;
                mark_seen <= 1'b0;
                ovf       <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_LSCAN: begin
          if (scan_done) begin
            count <= count + 1'b1;
            state <= S_IDLE;
          end
        end
        S_MREQ:  state <= S_MBASE;
        S_MBASE: state <= S_MSCAN;
        S_MSCAN: begin
          if (scan_done) begin
            state <= S_IDLE;
          end
        end
        S_RREQ:  state <= S_RDONE;
        S_RDONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item payload, scan pointers and result word
  always_ff @(posedge clk) begin
    pj <= scan_j[AW-1:0];
    if (issue) begin
      scan_j <= scan_j + 1'b1;
    end
    if (in_acc) begin
      h_x       <= in_x;
      h_y       <= in_y;
      h_z       <= in_z;
      h_idx     <= idx_cmp[AW-1:0];
      scan_j    <= '0;
      dup_found <= 1'b0;
      r_present <= culling_on && mark_seen;
      r_inrange <= idx_cmp < cnt_cmp;
    end
    if (state == S_LSCAN && pv && cmp.eq) begin
      dup_found <= 1'b1;
    end
    if (state == S_MBASE) begin
      h_x    <= rdata[3*CB-1:2*CB];
      h_y    <= rdata[2*CB-1:CB];
      h_z    <= rdata[CB-1:0];
      scan_j <= '0;
    end
    if (state == S_RDONE && (!out_valid || out_ready)) begin
      candidate      <= r_present && r_inrange && rdata[CAND];
      mask_present   <= r_present;
      index_in_range <= r_inrange;
      table_overflow <= ovf;
    end
  end

endmodule
